// ===== hw/rtl/twqa_pkg.sv =====
package twqa_pkg;

    // Fixed field widths
    localparam int QIDX_W  = 3;
    localparam int TOK_W   = 8;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 19;
    localparam int TABLE_W = 64;
    localparam int COST_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_ENQ   = 2'd0,
        KIND_DROP  = 2'd1,
        KIND_GRANT = 2'd2
    } t_kind;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFILL = 2'd0,
        CFG_CAP    = 2'd1,
        CFG_COST   = 2'd2
    } t_cfg_idx;

    // Controller states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SWEEP = 1'b1
    } t_state;

    // Request payload
    typedef struct packed {
        logic [1:0]        kind;
        logic [QIDX_W-1:0] queue_index;
    } t_req;

    // Result payload
    typedef struct packed {
        logic              grant_valid;
        logic [QIDX_W-1:0] granted_queue;
        logic [SUM_W-1:0]  total_pending;
    } t_res;

    // Running best candidate handed along the cell row
    typedef struct packed {
        logic               found;
        logic [TOK_W-1:0]   tokens;
        logic [COUNT_W-1:0] count;
        logic [QIDX_W-1:0]  sel;
    } t_best;

    // Per-cell update command from the controller
    typedef struct packed {
        logic inc;
        logic dec;
        logic take_cost;
    } t_cell_cmd;

    // Per-cell status back to the controller
    typedef struct packed {
        logic nonzero;
        logic full;
    } t_cell_stat;

endpackage

// ===== hw/rtl/twqa_cell.sv =====
module twqa_cell
    import twqa_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TOK_W-1:0]   i_refill,
    input  logic [TOK_W-1:0]   i_cap,
    input  logic [COST_W-1:0]  i_cost,
    input  t_cell_cmd          i_cmd,
    input  logic               i_go,
    input  t_best              i_best,
    output logic               o_go,
    output t_best              o_best,
    output t_cell_stat         o_stat
);

    logic [TOK_W-1:0]   r_tok;
    logic [TOK_W-1:0]   n_tok;
    logic [COUNT_W-1:0] r_cnt;
    logic [COUNT_W-1:0] n_cnt;
    logic               r_go;
    t_best              r_best;
    t_best              n_best;

    logic [TOK_W-1:0]   rate;
    logic [TOK_W-1:0]   cap;
    logic [TOK_W:0]     lvl;
    logic               take;

    // Treat zero table bytes as one
    assign rate = (i_refill == '0) ? TOK_W'(1) : i_refill;
    assign cap  = (i_cap == '0) ? TOK_W'(1) : i_cap;
    assign lvl  = {1'b0, r_tok} + {1'b0, rate};

    // Compare this queue against the incoming best, using pre-refill tokens
    assign take = (r_cnt != '0) &&
                  (!i_best.found || (r_tok > i_best.tokens) ||
                   ((r_tok == i_best.tokens) && (r_cnt > i_best.count)));

    always_comb begin
        n_best = i_best;
        if (take) begin
            n_best.found  = 1'b1;
            n_best.tokens = r_tok;
            n_best.count  = r_cnt;
            n_best.sel    = QIDX_W'(CELL_IDX);
        end
    end

    // Refill on the sweep pass, charge the cost when granted
    always_comb begin
        n_tok = r_tok;
        if (i_go) begin
            n_tok = (lvl < {1'b0, cap}) ? lvl[TOK_W-1:0] : cap;
        end else if (i_cmd.take_cost) begin
            n_tok = (r_tok > i_cost) ? (r_tok - i_cost) : '0;
        end
    end

    // Adjust the pending count
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.inc) begin
            n_cnt = r_cnt + COUNT_W'(1);
        end else if (i_cmd.dec) begin
            n_cnt = r_cnt - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
            r_cnt <= '0;
            r_go  <= 1'b0;
        end else begin
            r_tok <= n_tok;
            r_cnt <= n_cnt;
            r_go  <= i_go;
        end
    end

    // Hand the best candidate to the next cell
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_best <= n_best;
        end
    end

    assign o_go           = r_go;
    assign o_best         = r_best;
    assign o_stat.nonzero = (r_cnt != '0);
    assign o_stat.full    = (r_cnt == COUNT_MAX);

endmodule

// ===== hw/rtl/token_weighted_queue_arbiter.sv =====
// Token-weighted queue arbiter for one output port.
//
// Request channel: an enqueue, drop or grant request is taken at a clock edge
// with start high and busy low. Enqueue and drop update one queue in that cycle;
// their result appears in the next cycle and busy stays low, so they can be sent
// every cycle. A grant request runs a sweep along a row of NUM_QUEUES cells,
// one cell per cycle: each cell compares its queue against the best candidate
// handed from its left neighbor and refills its tokens. Busy is high while the
// sweep runs; the result is shown in the cycle busy falls, and the next request
// can be taken at the edge that ends that cycle.
// Results are shown for one cycle with o_res_strobe; the receiver cannot stall.
// Configuration writes (refill table, cap table, PDU cost) go through a
// valid/ready channel that is always ready; write only while idle.
// Reset (synchronous, active low) clears all counts, token levels and the
// pending sum, and loads the default tables.
module token_weighted_queue_arbiter
    import twqa_pkg::*;
#(
    parameter int NUM_QUEUES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    output logic                 o_res_strobe,
    output t_res                 o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TABLE_W-1:0]   i_cfg_data
);

    t_state               r_state;
    t_state               n_state;
    logic [TABLE_W-1:0]   r_refill;
    logic [TABLE_W-1:0]   r_cap;
    logic [COST_W-1:0]    r_cost;
    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     n_sum;
    logic                 r_strobe;
    logic                 n_strobe;
    t_res                 r_res;
    t_res                 n_res;

    logic                 accept;
    logic                 go_first;
    logic                 done;
    t_best                best_last;
    logic [NUM_QUEUES-1:0] hit;
    logic [NUM_QUEUES-1:0] nonzero;
    logic [NUM_QUEUES-1:0] full;
    logic                 enq_ok;
    logic                 drop_ok;
    logic                 is_enq;
    logic                 is_drop;

    logic      go_chain [NUM_QUEUES+1];
    t_best     best_chain [NUM_QUEUES+1];
    t_cell_cmd cmd [NUM_QUEUES];
    t_cell_stat stat [NUM_QUEUES];

    assign accept   = start && !busy;
    assign is_enq   = (i_req.kind == KIND_ENQ);
    assign is_drop  = (i_req.kind == KIND_DROP);
    assign go_first = accept && (i_req.kind == KIND_GRANT);

    // Seed the row with an empty candidate
    assign go_chain[0]   = go_first;
    assign best_chain[0] = '0;

    assign done      = go_chain[NUM_QUEUES];
    assign best_last = best_chain[NUM_QUEUES];

    genvar k;
    generate
        for (k = 0; k < NUM_QUEUES; k++) begin : g_cell
            assign hit[k]     = (i_req.queue_index == QIDX_W'(k));
            assign nonzero[k] = stat[k].nonzero;
            assign full[k]    = stat[k].full;

            // Route updates to this queue
            assign cmd[k].inc       = accept && is_enq && hit[k] && !full[k];
            assign cmd[k].dec       = (accept && is_drop && hit[k] && nonzero[k]) ||
                                      (done && best_last.found &&
                                       (best_last.sel == QIDX_W'(k)));
            assign cmd[k].take_cost = done && best_last.found &&
                                      (best_last.sel == QIDX_W'(k));

            twqa_cell #(
                .CELL_IDX (k)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_refill (r_refill[TOK_W*k +: TOK_W]),
                .i_cap    (r_cap[TOK_W*k +: TOK_W]),
                .i_cost   (r_cost),
                .i_cmd    (cmd[k]),
                .i_go     (go_chain[k]),
                .i_best   (best_chain[k]),
                .o_go     (go_chain[k+1]),
                .o_best   (best_chain[k+1]),
                .o_stat   (stat[k])
            );
        end
    endgenerate

    assign enq_ok  = |(hit & ~full);
    assign drop_ok = |(hit & nonzero);

    // Next state, pending sum and result
    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_strobe = 1'b0;
        n_res    = r_res;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_enq && enq_ok) begin
                        n_sum = r_sum + SUM_W'(1);
                    end else if (is_drop && drop_ok) begin
                        n_sum = r_sum - SUM_W'(1);
                    end
                    if (go_first) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_strobe            = 1'b1;
                        n_res.grant_valid   = 1'b0;
                        n_res.granted_queue = '0;
                        n_res.total_pending = n_sum;
                    end
                end
            end
            ST_SWEEP: begin
                if (done) begin
                    n_state = ST_IDLE;
                    if (best_last.found) begin
                        n_sum = r_sum - SUM_W'(1);
                    end
                    n_strobe            = 1'b1;
                    n_res.grant_valid   = best_last.found;
                    n_res.granted_queue = best_last.found ? best_last.sel : '0;
                    n_res.total_pending = n_sum;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sum    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refill <= 64'h0101_0101_0101_0101;
            r_cap    <= 64'h0505_0505_0505_0505;
            r_cost   <= COST_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REFILL: r_refill <= i_cfg_data;
                CFG_CAP:    r_cap    <= i_cfg_data;
                CFG_COST:   r_cost   <= i_cfg_data[COST_W-1:0];
                default:    ;
            endcase
        end
    end

    assign busy         = (r_state == ST_SWEEP);
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

// ===== hw/rtl/twqa_checker.sv =====
module twqa_checker
    import twqa_pkg::*;
#(
    parameter int NUM_QUEUES = 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_res_strobe,
    input t_res                 o_res
);

    // A grant sweep keeps busy high while it steps through every queue, then its result follows
    a_sweep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ##(NUM_QUEUES-1) busy ##1 (!busy && o_res_strobe))
        else $error("grant sweep length wrong");

    // Every result traces back to a taken request or a finished sweep
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> ($past(start && !busy) || $fell(busy)))
        else $error("result without request");

    // A granted queue only comes out of a sweep
    a_grant_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.grant_valid) |-> $fell(busy))
        else $error("grant outside sweep");

    // A result without a grant reports queue zero
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.grant_valid) |-> (o_res.granted_queue == '0))
        else $error("granted queue set without grant");

    // A granted queue lies within the configured queue count
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.grant_valid) |->
            (32'(o_res.granted_queue) < NUM_QUEUES))
        else $error("granted queue out of range");

endmodule

bind token_weighted_queue_arbiter twqa_checker #(
    .NUM_QUEUES (NUM_QUEUES)
) u_twqa_checker (.*);
